### hw/rtl/fcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants for the circular-store FIR filter.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int COEF_IDX_W  = 6;
    localparam int TAP_CNT_W   = 7;
    localparam int BUF_LAST_W  = 6;
    localparam int SHIFT_W     = 5;
    localparam int ACC_W       = 32;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LAST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_RIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NO_OUTPUT_CLIP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_OVERRANGE = 3'd4;

    localparam logic [TAP_CNT_W-1:0]  TAP_COUNT_RST   = 7'd1;
    localparam logic [BUF_LAST_W-1:0] BUFFER_LAST_RST = 6'd63;
    localparam logic [SHIFT_W-1:0]    SHIFT_RIGHT_RST = 5'd15;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef struct packed {
        logic start;
        logic coef_wr;
        logic issue;
        logic shift;
        logic load_out;
    } fcc_cmd_t;

    typedef struct packed {
        logic taps_zero;
        logic last_tap;
        logic pipe_empty;
    } fcc_sts_t;

endpackage

### hw/rtl/fir_filter_circular_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_circular_clip
// 16-bit FIR filter over a circular sample store with optional overrange
// saturation, arithmetic output shift and 16-bit clip or truncate.
// ----------------------------------------------------------------------------
// Sample request: tap count clamped to MAX_TAPS; one shared MAC issues one tap
// per cycle, then the MAC pipe drains, the sum is shifted and the result is
// loaded (zero taps skip the tap loop). The next request waits for the load.
// Coefficient-write request: no result. A held result stalls the next
// sample in its last cycle. Reset: settings to defaults, write position to zero;
// both stores read as zero until written (per-entry valid bits).
// ----------------------------------------------------------------------------
module fir_filter_circular_clip
    import fcc_pkg::*;
#(
    parameter int MAX_TAPS   = 64,
    parameter int RING_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       kind,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [COEF_IDX_W-1:0]      coeff_index,
    input  logic signed [COEF_W-1:0]   coeff_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] filtered,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    fcc_cmd_t cmd;
    fcc_sts_t sts;

    fcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    fcc_dp #(
        .MAX_TAPS   (MAX_TAPS),
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .cmd         (cmd),
        .sts         (sts),
        .filtered    (filtered)
    );

endmodule

### hw/rtl/fcc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/fcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_ctrl
// Sequencer: takes requests, steps the tap loop, drains the MAC pipe,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module fcc_ctrl
    import fcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     kind,
    output logic     in_stall,
    input  logic     out_stall,
    output logic     out_valid,
    input  fcc_sts_t sts,
    output fcc_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_acc;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (kind == KIND_COEF)
                    begin
                        cmd.coef_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = sts.taps_zero ? ST_DRAIN : ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (sts.last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_shift_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> sts.pipe_empty)
        else $error("shift entered with MAC pipe busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a pending one");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside done state");

    a_start_issues: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && !sts.taps_zero) |=> (state_reg == ST_ISSUE))
        else $error("sample request did not start tap loop");

endmodule

### hw/rtl/fcc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_dp
// Datapath: settings, sample ring and coefficient stores, one shared
// multiply-accumulate with optional saturation, output shift and clip or truncate.
// ----------------------------------------------------------------------------
module fcc_dp
    import fcc_pkg::*;
#(
    parameter int MAX_TAPS   = 64,
    parameter int RING_DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [SAMPLE_W-1:0]   sample,
    input  logic [COEF_IDX_W-1:0]        coeff_index,
    input  logic signed [COEF_W-1:0]     coeff_value,
    input  fcc_cmd_t                     cmd,
    output fcc_sts_t                     sts,
    output logic signed [SAMPLE_W-1:0]   filtered
);

    localparam int RAW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CAW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TCW  = $clog2(MAX_TAPS + 1);
    localparam int CMPW = 10;

    logic [TAP_CNT_W-1:0]  tap_count_reg;
    logic [BUF_LAST_W-1:0] buffer_last_reg;
    logic [SHIFT_W-1:0]    shift_right_reg;
    logic                  no_output_clip_reg;
    logic                  check_overrange_reg;

    logic [CMPW-1:0] taps_cmp;
    logic [CMPW-1:0] taps_lim;
    logic [TCW-1:0]  taps_eff;
    logic [CMPW-1:0] last_cmp;
    logic [CMPW-1:0] last_lim;
    logic [RAW-1:0]  last_eff;
    logic [CMPW-1:0] cidx_cmp;
    logic            cidx_ok;

    logic [RAW-1:0]  write_pos_reg;
    logic [RAW-1:0]  p_reg;
    logic [TCW-1:0]  k_reg;

    logic [RING_DEPTH-1:0] ring_vld_reg;
    logic [MAX_TAPS-1:0]   coef_vld_reg;
    logic                  s_vld_reg;
    logic                  c_vld_reg;
    logic [SAMPLE_W-1:0]   ring_rdata;
    logic [COEF_W-1:0]     coef_rdata;
    logic                  ring_wr;
    logic                  coef_wr;

    logic                  rd_v_reg;
    logic                  mul_v_reg;
    logic signed [SAMPLE_W-1:0] s_op;
    logic signed [COEF_W-1:0]   c_op;
    logic signed [ACC_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       sat_reg;
    logic signed [ACC_W:0]      sum_w;
    logic                       ovf;
    logic signed [ACC_W-1:0]    sh_reg;
    logic signed [SAMPLE_W-1:0] clip_w;
    logic signed [SAMPLE_W-1:0] filtered_reg;

    // settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg       <= TAP_COUNT_RST;
            buffer_last_reg     <= BUFFER_LAST_RST;
            shift_right_reg     <= SHIFT_RIGHT_RST;
            no_output_clip_reg  <= 1'b0;
            check_overrange_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TAP_COUNT:       tap_count_reg       <= cfg_data[TAP_CNT_W-1:0];
                REG_BUFFER_LAST:     buffer_last_reg     <= cfg_data[BUF_LAST_W-1:0];
                REG_SHIFT_RIGHT:     shift_right_reg     <= cfg_data[SHIFT_W-1:0];
                REG_NO_OUTPUT_CLIP:  no_output_clip_reg  <= cfg_data[0];
                REG_CHECK_OVERRANGE: check_overrange_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // effective tap count and ring end
    assign taps_cmp = CMPW'(tap_count_reg);
    assign taps_lim = (taps_cmp > CMPW'(MAX_TAPS)) ? CMPW'(MAX_TAPS) : taps_cmp;
    assign taps_eff = taps_lim[TCW-1:0];
    assign last_cmp = CMPW'(buffer_last_reg);
    assign last_lim = (last_cmp >= CMPW'(RING_DEPTH)) ? CMPW'(RING_DEPTH - 1) : last_cmp;
    assign last_eff = last_lim[RAW-1:0];
    assign cidx_cmp = CMPW'(coeff_index);
    assign cidx_ok  = (cidx_cmp < CMPW'(MAX_TAPS));

    assign sts.taps_zero  = (taps_eff == '0);
    assign sts.last_tap   = (k_reg == taps_eff - TCW'(1));
    assign sts.pipe_empty = !rd_v_reg && !mul_v_reg;

    assign ring_wr = cmd.start;
    assign coef_wr = cmd.coef_wr && cidx_ok;

    fcc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (write_pos_reg),
        .wr_data (sample),
        .rd_addr (p_reg),
        .rd_data (ring_rdata)
    );

    fcc_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef (
        .clk     (clk),
        .wr_en   (coef_wr),
        .wr_addr (cidx_cmp[CAW-1:0]),
        .wr_data (coeff_value),
        .rd_addr (k_reg[CAW-1:0]),
        .rd_data (coef_rdata)
    );

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
            coef_vld_reg <= '0;
        end
        else
        begin
            if (ring_wr)
            begin
                ring_vld_reg[write_pos_reg] <= 1'b1;
            end
            if (coef_wr)
            begin
                coef_vld_reg[cidx_cmp[CAW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= cmd.issue;
            mul_v_reg <= rd_v_reg;
            if (cmd.start)
            begin
                write_pos_reg <= (write_pos_reg >= last_eff) ? '0 : write_pos_reg + RAW'(1);
            end
        end
    end

    // tap walk: newest sample backward, coefficients forward
    always_ff @(posedge clk)
    begin
        s_vld_reg <= ring_vld_reg[p_reg];
        c_vld_reg <= coef_vld_reg[k_reg[CAW-1:0]];
        if (cmd.start)
        begin
            p_reg <= write_pos_reg;
            k_reg <= '0;
        end
        else if (cmd.issue)
        begin
            p_reg <= (p_reg == '0) ? last_eff : p_reg - RAW'(1);
            k_reg <= k_reg + TCW'(1);
        end
    end

    assign s_op  = s_vld_reg ? $signed(ring_rdata) : '0;
    assign c_op  = c_vld_reg ? $signed(coef_rdata) : '0;
    assign sum_w = {acc_reg[ACC_W-1], acc_reg} + {prod_reg[ACC_W-1], prod_reg};
    assign ovf   = sum_w[ACC_W] ^ sum_w[ACC_W-1];

    always_ff @(posedge clk)
    begin
        prod_reg <= s_op * c_op;
        if (cmd.start)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (mul_v_reg && !sat_reg)
        begin
            if (check_overrange_reg && ovf)
            begin
                // clip toward the overflow direction and freeze
                acc_reg <= sum_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                        : {1'b0, {(ACC_W-1){1'b1}}};
                sat_reg <= 1'b1;
            end
            else
            begin
                acc_reg <= sum_w[ACC_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (sh_reg > 32'sd32767)
        begin
            clip_w = 16'sh7FFF;
        end
        else if (sh_reg < -32'sd32768)
        begin
            clip_w = 16'sh8000;
        end
        else
        begin
            clip_w = sh_reg[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            sh_reg <= acc_reg >>> shift_right_reg;
        end
        if (cmd.load_out)
        begin
            filtered_reg <= no_output_clip_reg ? sh_reg[SAMPLE_W-1:0] : clip_w;
        end
    end

    assign filtered = filtered_reg;

endmodule

### verif/fir_filter_circular_clip_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_circular_clip_test
// Self-checking bench for the circular-store FIR filter. A local filter
// predictor tracks the sample ring, coefficients, write position and settings,
// and each accepted sample request queues its expected filtered value. A
// directed pass covers reset defaults, the output shift, clip and truncate,
// overrange saturation, tap count and store length corners, ignored register
// indexes, and a write position left past a shortened store. Random traffic
// then runs under changing settings and idle patterns on both sides,
// including a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module fir_filter_circular_clip_test;
    import fcc_pkg::*;

    localparam int TAPS_MAX     = 64;
    localparam int RING_SIZE    = 64;
    localparam int SETTLE       = 80;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_ITEMS  = 430;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       kind = KIND_SAMPLE;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic [COEF_IDX_W-1:0]      coeff_index = '0;
    logic signed [COEF_W-1:0]   coeff_value = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    logic                       hold_off = 1'b0;
    int                         send_idle_pct = 0;
    int                         recv_idle_pct = 0;

    // predictor state
    logic signed [SAMPLE_W-1:0] ring_copy [RING_SIZE];
    logic signed [COEF_W-1:0]   coef_copy [TAPS_MAX];
    int unsigned                wr_pos;
    logic [TAP_CNT_W-1:0]       tap_setting;
    logic [BUF_LAST_W-1:0]      last_setting;
    logic [SHIFT_W-1:0]         shift_setting;
    logic                       truncate_setting;
    logic                       overrange_setting;

    logic signed [SAMPLE_W-1:0] expected_filtered [$];

    int errors = 0;
    int cycles = 0;
    int n_samples = 0;
    int n_coefs = 0;
    int n_results = 0;
    int n_settings = 0;

    fir_filter_circular_clip i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .sample      (sample),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .filtered    (filtered),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_filtered.size());
            $display("fir_filter_circular_clip_test: errors");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);

    function automatic void predictor_reset();
        for (int i = 0; i < RING_SIZE; i++)
            ring_copy[i] = '0;
        for (int i = 0; i < TAPS_MAX; i++)
            coef_copy[i] = '0;
        wr_pos            = 0;
        tap_setting       = TAP_COUNT_RST;
        last_setting      = BUFFER_LAST_RST;
        shift_setting     = SHIFT_RIGHT_RST;
        truncate_setting  = 1'b0;
        overrange_setting = 1'b0;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] filter_step(
        input logic signed [SAMPLE_W-1:0] smp);
        int unsigned             last;
        int unsigned             taps;
        int unsigned             p;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] term;
        logic signed [ACC_W-1:0] shifted;
        longint                  sum;
        last = (last_setting >= RING_SIZE) ? RING_SIZE - 1 : last_setting;
        taps = (tap_setting > TAPS_MAX) ? TAPS_MAX : tap_setting;
        if (wr_pos >= RING_SIZE)
            wr_pos = 0;
        ring_copy[wr_pos] = smp;
        p = wr_pos;
        acc = '0;
        for (int k = 0; k < taps; k++)
        begin
            term = ring_copy[p] * coef_copy[k];
            if (overrange_setting)
            begin
                sum = longint'(acc) + longint'(term);
                if (sum > 64'sd2147483647)
                begin
                    acc = 32'h7FFF_FFFF;
                    break;
                end
                if (sum < -64'sd2147483648)
                begin
                    acc = 32'h8000_0000;
                    break;
                end
                acc = sum[ACC_W-1:0];
            end
            else
                acc = acc + term;
            if (p == 0)
                p = last;
            else
                p--;
            if (p >= RING_SIZE)
                p = RING_SIZE - 1;
        end
        if (wr_pos >= last)
            wr_pos = 0;
        else
            wr_pos++;
        shifted = acc >>> shift_setting;
        if (truncate_setting)
            return shifted[SAMPLE_W-1:0];
        if (shifted > 32767)
            return 16'sh7FFF;
        if (shifted < -32768)
            return 16'sh8000;
        return shifted[SAMPLE_W-1:0];
    endfunction

    task automatic note_error(input string what, input int exp_v, input int act_v);
        errors++;
        if (errors <= 10)
            $display("mismatch at cycle %0d: %s expected %0d got %0d", cycles, what,
                     exp_v, act_v);
    endtask

    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            n_results++;
            if (expected_filtered.size() == 0)
                note_error("unrequested result, pending", 0, filtered);
            else
            begin
                want = expected_filtered.pop_front();
                if (filtered !== want)
                    note_error("filtered", want, filtered);
            end
        end
    end

    // Leaves in_valid high after acceptance so requests can go back to back.
    task automatic send_request(input logic k, input logic signed [SAMPLE_W-1:0] smp,
                                input logic [COEF_IDX_W-1:0] idx,
                                input logic signed [COEF_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        sample      <= smp;
        coeff_index <= idx;
        coeff_value <= val;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (k == KIND_COEF)
        begin
            coef_copy[idx] = val;
            n_coefs++;
        end
        else
        begin
            expected_filtered.push_back(filter_step(smp));
            n_samples++;
        end
    endtask

    task automatic sample_req(input logic signed [SAMPLE_W-1:0] smp);
        send_request(KIND_SAMPLE, smp, COEF_IDX_W'($urandom()), COEF_W'($urandom()));
    endtask

    task automatic coef_req(input logic [COEF_IDX_W-1:0] idx,
                            input logic signed [COEF_W-1:0] val);
        send_request(KIND_COEF, SAMPLE_W'($urandom()), idx, val);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_filtered.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_TAP_COUNT:       tap_setting       = val[TAP_CNT_W-1:0];
            REG_BUFFER_LAST:     last_setting      = val[BUF_LAST_W-1:0];
            REG_SHIFT_RIGHT:     shift_setting     = val[SHIFT_W-1:0];
            REG_NO_OUTPUT_CLIP:  truncate_setting  = val[0];
            REG_CHECK_OVERRANGE: overrange_setting = val[0];
            default: ;
        endcase
        n_settings++;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return 16'sh8000;
        if (pick < 30)
            return 16'sh7FFF;
        if (pick < 50)
            return 16'($signed($urandom_range(0, 511)) - 256);
        return 16'($urandom());
    endfunction

    task automatic random_settings();
        logic [6:0] taps;
        logic [6:0] shift;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            taps = 7'($urandom_range(0, 8));
        else if (pick < 85)
            taps = 7'($urandom_range(9, 64));
        else
            taps = 7'($urandom_range(65, 127));
        shift = 7'($urandom());
        if ($urandom_range(0, 3) != 0)
            shift[4:0] = 5'($urandom_range(12, 18));
        write_reg(REG_TAP_COUNT, taps);
        write_reg(REG_BUFFER_LAST, 7'($urandom()));
        write_reg(REG_SHIFT_RIGHT, shift);
        write_reg(REG_NO_OUTPUT_CLIP, 7'($urandom()));
        write_reg(REG_CHECK_OVERRANGE, 7'($urandom()));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(5, 7)), 7'($urandom()));
    endtask

    task automatic random_request();
        if ($urandom_range(0, 99) < 25)
            coef_req(COEF_IDX_W'($urandom()), pick_value());
        else
            sample_req(pick_value());
    endtask

    task automatic test_reset_defaults();
        sample_req(16'sh7FFF);
        coef_req(6'd0, 16'sh8000);
        sample_req(16'sh8000);
        sample_req(16'sh7FFF);
        coef_req(6'd63, 16'sh7FFF);
        drain();
    endtask

    task automatic test_output_stage();
        write_reg(REG_SHIFT_RIGHT, 7'd0);
        sample_req(16'sd12345);
        drain();
        write_reg(REG_NO_OUTPUT_CLIP, 7'd1);
        sample_req(16'sd12345);
        drain();
        write_reg(REG_SHIFT_RIGHT, 7'd31);
        sample_req(16'sd5);
        drain();
        write_reg(REG_NO_OUTPUT_CLIP, 7'd0);
    endtask

    task automatic test_overrange();
        write_reg(REG_TAP_COUNT, 7'd4);
        write_reg(REG_SHIFT_RIGHT, 7'd16);
        write_reg(REG_CHECK_OVERRANGE, 7'd1);
        for (int i = 1; i < 4; i++)
            coef_req(COEF_IDX_W'(i), 16'sh8000);
        sample_req(16'sh8000);
        sample_req(16'sh8000);
        for (int i = 0; i < 4; i++)
            sample_req(16'sh7FFF);
        drain();
        write_reg(REG_CHECK_OVERRANGE, 7'd0);
        sample_req(16'sh7FFF);
        sample_req(16'sh8000);
        drain();
    endtask

    task automatic test_taps_and_store();
        write_reg(REG_TAP_COUNT, 7'd0);
        sample_req(16'sh7FFF);
        drain();
        write_reg(REG_TAP_COUNT, 7'd127);
        sample_req(16'sh8000);
        drain();
        write_reg(REG_TAP_COUNT, 7'd4);
        write_reg(REG_BUFFER_LAST, 7'd0);
        sample_req(16'sd1000);
        sample_req(-16'sd2000);
        drain();
        write_reg(3'd5, 7'h7F);
        write_reg(3'd6, 7'h55);
        write_reg(3'd7, 7'h2A);
        write_reg(REG_BUFFER_LAST, 7'd63);
        for (int i = 0; i < 5; i++)
            sample_req(16'(3000 * (i + 1)));
        drain();
        // write position now sits past the shortened store
        write_reg(REG_BUFFER_LAST, 7'd2);
        sample_req(-16'sd7);
        sample_req(16'sd9);
        drain();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int sent;
        int chunk;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            random_settings();
            chunk = $urandom_range(15, 40);
            for (int i = 0; i < chunk; i++)
                random_request();
            sent += chunk;
            drain();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_TAP_COUNT, 7'd2);
        write_reg(REG_BUFFER_LAST, 7'd63);
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++)
            random_request();
        drain();
    endtask

    initial
    begin
        predictor_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_output_stage();
        test_overrange();
        test_taps_and_store();
        test_random_traffic(16, 78);
        test_random_traffic(78, 16);
        test_random_traffic(0, 0);
        test_backpressure();
        drain();

        if (expected_filtered.size() != 0)
            note_error("results still pending", 0, expected_filtered.size());
        $display("covered %0d sample and %0d coefficient requests, %0d results checked",
                 n_samples, n_coefs, n_results);
        $display("across %0d register writes, three idle patterns and a long output hold",
                 n_settings);
        if (errors == 0)
            $display("fir_filter_circular_clip_test: clean");
        else
            $display("fir_filter_circular_clip_test: errors");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/fcc_pkg.sv
hw/rtl/fcc_ram.sv
hw/rtl/fcc_ctrl.sv
hw/rtl/fcc_dp.sv
hw/rtl/fir_filter_circular_clip.sv
verif/fir_filter_circular_clip_test.sv
